/* rtl/core/les_pkg.sv */
// Shared types, reset values and saturating Q12.20 arithmetic for the Lorenz Euler step core.
package les_pkg;

  localparam int Q_W     = 32;
  localparam int FRAC_W  = 20;
  localparam int DT_W    = 20;
  localparam int PROD_W  = 2 * Q_W;
  localparam int SHIFT_W = PROD_W - FRAC_W;
  localparam int STAGES  = 10;

  typedef logic signed [Q_W-1:0]     q_t;
  typedef logic        [DT_W-1:0]    dt_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SHIFT_W-1:0] shifted_t;
  typedef logic        [STAGES-1:0]  stage_vec_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_SIGMA     = 2'd0,
    CFG_RHO       = 2'd1,
    CFG_BETA      = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    q_t  sigma;
    q_t  rho;
    q_t  beta;
    dt_t time_step;
  } cfg_t;

  localparam q_t  SIGMA_RST     = 32'sd10485760;
  localparam q_t  RHO_RST       = 32'sd29360128;
  localparam q_t  BETA_RST      = 32'sd2796203;
  localparam dt_t TIME_STEP_RST = 20'd10486;

  localparam q_t    Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t    Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam prod_t RND   = prod_t'(1) <<< (FRAC_W - 1);

  // Saturating sum of two Q values
  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  // Saturating difference a - b
  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  // Fixed-point product: round half up, drop fraction bits, saturate
  function automatic q_t qmul(input q_t a, input q_t b);
    prod_t    p;
    shifted_t w;
    p = prod_t'(a) * prod_t'(b);
    p = p + RND;
    w = p[PROD_W-1:FRAC_W];
    if (w[SHIFT_W-1:Q_W-1] == '0 || w[SHIFT_W-1:Q_W-1] == '1) begin
      return w[Q_W-1:0];
    end
    return w[SHIFT_W-1] ? Q_MIN : Q_MAX;
  endfunction

  // Widen the unsigned time step to a non-negative Q operand
  function automatic q_t dt_to_q(input dt_t dt);
    return q_t'({{(Q_W-DT_W){1'b0}}, dt});
  endfunction

endpackage

/* rtl/core/les_cfg.sv */
// Configuration register file: sigma, rho, beta and time step.
module les_cfg import les_pkg::*; #(
  parameter int CFG_INDEX_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]         cfg_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  // Always take a write word; unknown indexes drop silently
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sigma     <= SIGMA_RST;
      cfg_r.rho       <= RHO_RST;
      cfg_r.beta      <= BETA_RST;
      cfg_r.time_step <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INDEX_W'(CFG_SIGMA)) begin
        cfg_r.sigma <= q_t'(cfg_data);
      end
      if (cfg_index == CFG_INDEX_W'(CFG_RHO)) begin
        cfg_r.rho <= q_t'(cfg_data);
      end
      if (cfg_index == CFG_INDEX_W'(CFG_BETA)) begin
        cfg_r.beta <= q_t'(cfg_data);
      end
      if (cfg_index == CFG_INDEX_W'(CFG_TIME_STEP)) begin
        cfg_r.time_step <= cfg_data[DT_W-1:0];
      end
    end
  end

endmodule

/* rtl/core/les_pipe_ctrl.sv */
// Pipeline control: per-stage valid bits and bubble-collapsing load enables.
module les_pipe_ctrl import les_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output stage_vec_t en
);

  stage_vec_t vld_r;

  // A stage loads when it is empty or its word moves on
  always_comb begin
    en[STAGES-1] = ~vld_r[STAGES-1] | out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

`ifndef NO_ASSERTIONS
  // An open output lets every stage move
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> (en == '1))
    else $error("stage enables low while output is open");

  // A blocked first stage holds its word
  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !en[0]) |=> vld_r[0])
    else $error("first stage dropped a stalled word");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("valid bits survive reset");
`endif

endmodule

/* rtl/core/les_datapath.sv */
// Ten-stage saturating Q12.20 datapath for one Euler step of the Lorenz system.
module les_datapath import les_pkg::*; (
  input  logic       clk,
  input  stage_vec_t en,
  input  cfg_t       cfg,
  input  q_t         pos_x,
  input  q_t         pos_y,
  input  q_t         pos_z,
  output q_t         next_x,
  output q_t         next_y,
  output q_t         next_z,
  output q_t         vel_x,
  output q_t         vel_y,
  output q_t         vel_z
);

  q_t x0_r, y0_r, z0_r, dxy0_r, rz0_r;
  q_t x1_r, y1_r, z1_r, t1_1_r, t2_1_r, bz1_r;
  q_t x2_r, y2_r, z2_r, bz2_r, u1_2_r, t2b_2_r;
  q_t x3_r, y3_r, z3_r, bz3_r, nx3_r, u2_3_r;
  q_t x4_r, y4_r, z4_r, bz4_r, nx4_r, ny4_r, vx4_r;
  q_t z5_r, bz5_r, nx5_r, ny5_r, vx5_r, vy5_r, p5_r;
  q_t z6_r, nx6_r, ny6_r, vx6_r, vy6_r, t3_6_r;
  q_t z7_r, nx7_r, ny7_r, vx7_r, vy7_r, u3_7_r;
  q_t z8_r, nx8_r, ny8_r, vx8_r, vy8_r, nz8_r;
  q_t nx9_r, ny9_r, nz9_r, vx9_r, vy9_r, vz9_r;
  q_t dt_q;

  assign dt_q = dt_to_q(cfg.time_step);

  // Stage 0: capture point, form y - x and rho - z
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r   <= pos_x;
      y0_r   <= pos_y;
      z0_r   <= pos_z;
      dxy0_r <= sat_sub(pos_y, pos_x);
      rz0_r  <= sat_sub(cfg.rho, pos_z);
    end
  end

  // Stage 1: sigma*(y-x), x*(rho-z), beta*z
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      z1_r   <= z0_r;
      t1_1_r <= qmul(cfg.sigma, dxy0_r);
      t2_1_r <= qmul(x0_r, rz0_r);
      bz1_r  <= qmul(cfg.beta, z0_r);
    end
  end

  // Stage 2: scale x rate by dt, form y rate x*(rho-z) - y
  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      bz2_r   <= bz1_r;
      u1_2_r  <= qmul(dt_q, t1_1_r);
      t2b_2_r <= sat_sub(t2_1_r, y1_r);
    end
  end

  // Stage 3: new x, scale y rate by dt
  always_ff @(posedge clk) begin
    if (en[3]) begin
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      z3_r   <= z2_r;
      bz3_r  <= bz2_r;
      nx3_r  <= sat_add(x2_r, u1_2_r);
      u2_3_r <= qmul(dt_q, t2b_2_r);
    end
  end

  // Stage 4: new y, x displacement
  always_ff @(posedge clk) begin
    if (en[4]) begin
      x4_r  <= x3_r;
      y4_r  <= y3_r;
      z4_r  <= z3_r;
      bz4_r <= bz3_r;
      nx4_r <= nx3_r;
      ny4_r <= sat_add(y3_r, u2_3_r);
      vx4_r <= sat_sub(x3_r, nx3_r);
    end
  end

  // Stage 5: x times new y, y displacement
  always_ff @(posedge clk) begin
    if (en[5]) begin
      z5_r  <= z4_r;
      bz5_r <= bz4_r;
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
      vx5_r <= vx4_r;
      vy5_r <= sat_sub(y4_r, ny4_r);
      p5_r  <= qmul(x4_r, ny4_r);
    end
  end

  // Stage 6: z rate
  always_ff @(posedge clk) begin
    if (en[6]) begin
      z6_r   <= z5_r;
      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      vx6_r  <= vx5_r;
      vy6_r  <= vy5_r;
      t3_6_r <= sat_sub(p5_r, bz5_r);
    end
  end

  // Stage 7: scale z rate by dt
  always_ff @(posedge clk) begin
    if (en[7]) begin
      z7_r   <= z6_r;
      nx7_r  <= nx6_r;
      ny7_r  <= ny6_r;
      vx7_r  <= vx6_r;
      vy7_r  <= vy6_r;
      u3_7_r <= qmul(dt_q, t3_6_r);
    end
  end

  // Stage 8: new z
  always_ff @(posedge clk) begin
    if (en[8]) begin
      z8_r  <= z7_r;
      nx8_r <= nx7_r;
      ny8_r <= ny7_r;
      vx8_r <= vx7_r;
      vy8_r <= vy7_r;
      nz8_r <= sat_add(z7_r, u3_7_r);
    end
  end

  // Stage 9: z displacement, output register
  always_ff @(posedge clk) begin
    if (en[9]) begin
      nx9_r <= nx8_r;
      ny9_r <= ny8_r;
      nz9_r <= nz8_r;
      vx9_r <= vx8_r;
      vy9_r <= vy8_r;
      vz9_r <= sat_sub(z8_r, nz8_r);
    end
  end

  assign next_x = nx9_r;
  assign next_y = ny9_r;
  assign next_z = nz9_r;
  assign vel_x  = vx9_r;
  assign vel_y  = vy9_r;
  assign vel_z  = vz9_r;

endmodule

/* rtl/core/lorenz_euler_step_core.sv */
// Top level of the Lorenz Euler step core: config registers, control and datapath.
//
// Usage:
//   in_*   : one word per point (pos_x, pos_y, pos_z), signed Q12.20.
//   out_*  : one word per point: next_x/y/z and vel_x/y/z (old minus new),
//            signed Q12.20, every intermediate saturated to 32 bits.
//   cfg_*  : register writes; index 0 sigma, 1 rho, 2 beta, 3 time_step
//            (Q0.20, low 20 bits of cfg_data). Other indexes are ignored.
//            cfg_ready is always high; write only while no word is in flight.
// Timing:
//   Ten register stages. One word per cycle sustained while out_ready is high;
//   the depth is set by the multiply chain x*(rho-z) -> dt -> new y -> x*ny
//   -> dt.
// Stall:
//   When out_ready is low the last stage holds; earlier empty stages still
//   fill, so in_ready stays high until every stage holds a word.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and loads the
//   default sigma 10, rho 28, beta 8/3 and time step 0.01.
module lorenz_euler_step_core import les_pkg::*; #(
  parameter int CFG_INDEX_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_pos_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_next_x,
  output logic signed [31:0]     out_next_y,
  output logic signed [31:0]     out_next_z,
  output logic signed [31:0]     out_vel_x,
  output logic signed [31:0]     out_vel_y,
  output logic signed [31:0]     out_vel_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t       cfg;
  stage_vec_t en;

  les_cfg #(
    .CFG_INDEX_W (CFG_INDEX_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  les_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  les_datapath u_dp (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .pos_x  (in_pos_x),
    .pos_y  (in_pos_y),
    .pos_z  (in_pos_z),
    .next_x (out_next_x),
    .next_y (out_next_y),
    .next_z (out_next_z),
    .vel_x  (out_vel_x),
    .vel_y  (out_vel_y),
    .vel_z  (out_vel_z)
  );

endmodule
